[sv/lcrt_pkg.sv]
// Shared types and opcode constants for the lowest-cost route table.
`timescale 1ns / 1ps
`default_nettype none

package lcrt_pkg;

  localparam int unsigned KIND_W = 8;
  localparam int unsigned OP_W   = 2;

  localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd1;
  localparam logic [OP_W-1:0] OP_READ     = 2'd2;
  localparam logic [OP_W-1:0] OP_CONTAINS = 2'd3;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;    // latch compare flags against the incoming item
    logic shift_en;  // apply the insert to the row
    logic ins_ok;    // the new route finds a place below the limit
  } lcrt_ctl_t;

  // Chain passed from a cell to its right-hand neighbor.
  typedef struct packed {
    logic after_m;   // a matching entry sits at or left of this cell
    logic r_le;      // compacted entry here costs no more than the new route
  } lcrt_link_t;

  // Per-cell flags gathered by the sequencer.
  typedef struct packed {
    logic match_lt;  // matching entry is strictly cheaper than the new route
    logic hit;       // live entry holds the looked-up value
  } lcrt_stat_t;

endpackage

`default_nettype wire

[sv/lcrt_cell.sv]
// One slot of the route row: holds a route, compares it, and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module lcrt_cell import lcrt_pkg::*; #(
  parameter int unsigned COST_BITS  = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire                        clk_i,
  input  lcrt_ctl_t                  ctl_i,
  input  wire                        live_i,
  input  wire        [COST_BITS-1:0] cmp_cost_i,
  input  wire       [VALUE_BITS-1:0] cmp_value_i,
  input  wire           [KIND_W-1:0] cmp_kind_i,
  input  wire        [COST_BITS-1:0] new_cost_i,
  input  wire       [VALUE_BITS-1:0] new_value_i,
  input  wire           [KIND_W-1:0] new_kind_i,
  input  wire        [COST_BITS-1:0] left_cost_i,
  input  wire       [VALUE_BITS-1:0] left_value_i,
  input  wire           [KIND_W-1:0] left_kind_i,
  input  wire        [COST_BITS-1:0] right_cost_i,
  input  wire       [VALUE_BITS-1:0] right_value_i,
  input  wire           [KIND_W-1:0] right_kind_i,
  input  wire                        le_right_i,
  output logic                       le_o,
  input  lcrt_link_t                 link_i,
  output lcrt_link_t                 link_o,
  output lcrt_stat_t                 stat_o,
  output logic       [COST_BITS-1:0] cost_o,
  output logic      [VALUE_BITS-1:0] value_o,
  output logic          [KIND_W-1:0] kind_o
);

  logic  [COST_BITS-1:0] cost_q, cost_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic     [KIND_W-1:0] kind_q, kind_d;
  logic                  le_q, match_q, lt_q, hit_q;
  logic                  after_m, r_le, at_pos;

  always_ff @(posedge clk_i) begin
    if (ctl_i.cmp_en) begin
      le_q    <= live_i && (cost_q <= cmp_cost_i);
      match_q <= live_i && (value_q == cmp_value_i) && (kind_q == cmp_kind_i);
      lt_q    <= cost_q < cmp_cost_i;
      hit_q   <= live_i && (value_q == cmp_value_i);
    end
  end

  // Position in the row after the matching entry is taken out.
  assign after_m = link_i.after_m | match_q;
  assign r_le    = after_m ? le_right_i : le_q;
  assign at_pos  = link_i.r_le & ~r_le;

  always_comb begin
    cost_d  = cost_q;
    value_d = value_q;
    kind_d  = kind_q;
    if (ctl_i.shift_en) begin
      if (ctl_i.ins_ok && !r_le && at_pos) begin
        cost_d  = new_cost_i;
        value_d = new_value_i;
        kind_d  = new_kind_i;
      end else if (ctl_i.ins_ok && !r_le) begin
        if (!link_i.after_m) begin
          cost_d  = left_cost_i;
          value_d = left_value_i;
          kind_d  = left_kind_i;
        end
      end else if (after_m) begin
        cost_d  = right_cost_i;
        value_d = right_value_i;
        kind_d  = right_kind_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cost_q  <= cost_d;
    value_q <= value_d;
    kind_q  <= kind_d;
  end

  assign le_o           = le_q;
  assign link_o.after_m = after_m;
  assign link_o.r_le    = r_le;
  assign stat_o.match_lt = match_q & lt_q;
  assign stat_o.hit      = hit_q;
  assign cost_o  = cost_q;
  assign value_o = value_q;
  assign kind_o  = kind_q;

endmodule

`default_nettype wire

[sv/lowest_cost_route_table_core.sv]
// Top level of the lowest-cost route table: sequencer, row of route cells, result register.
//
// Input channel: in_valid_i / in_stall_o carries one command (insert, clear,
// read at slot_index_i, contains route_value_i). A transfer happens when valid
// is high and stall is low. Output channel: out_valid_o / out_stall_i carries
// one result per command, in order.
// Each command goes through a compare step and an update step: in the transfer
// cycle every cell compares its route against the item and latches flags; in
// the update state the sequencer settles the drop/insert decision and all cells
// shift, load or hold together while the result is written to the output
// register. The update waits while a result is held under out_stall_i, and a
// new command is taken once the block has returned to idle.
// A result waiting under out_stall_i does not block the next transfer; that
// command then holds in its update cycle until the output register frees.
// cfg_we_i / cfg_wdata_i set the table limit (0 acts as 1, above SLOTS as
// SLOTS); write it only while idle. Reset empties the table and sets the
// limit to SLOTS; the route storage itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module lowest_cost_route_table_core import lcrt_pkg::*; #(
  parameter int unsigned SLOTS      = 4,
  parameter int unsigned COST_BITS  = 32,
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned CNT_W     = $clog2(SLOTS + 1),
  localparam int unsigned IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire       [CNT_W-1:0] cfg_wdata_i,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire        [OP_W-1:0] opcode_i,
  input  wire   [COST_BITS-1:0] route_cost_i,
  input  wire  [VALUE_BITS-1:0] route_value_i,
  input  wire      [KIND_W-1:0] route_kind_i,
  input  wire       [IDX_W-1:0] slot_index_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output logic      [CNT_W-1:0] entry_count_o,
  output logic                  accepted_o,
  output logic                  value_found_o,
  output logic                  entry_valid_o,
  output logic  [COST_BITS-1:0] entry_cost_o,
  output logic [VALUE_BITS-1:0] entry_value_o,
  output logic     [KIND_W-1:0] entry_kind_o
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_UPDATE = 1'b1;

  function automatic logic [CNT_W-1:0] clamp_lim(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > CNT_W'(SLOTS)) r = CNT_W'(SLOTS);
    return r;
  endfunction

  // Control state.
  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] slots_q;
  logic             out_valid_q;

  // Command held for the update cycle.
  logic       [OP_W-1:0] op_q;
  logic  [COST_BITS-1:0] cost_q;
  logic [VALUE_BITS-1:0] value_q;
  logic     [KIND_W-1:0] kind_q;
  logic      [IDX_W-1:0] idx_q;

  // Result register.
  logic      [CNT_W-1:0] res_count_q;
  logic                  res_acc_q, res_found_q, res_valid_q;
  logic  [COST_BITS-1:0] res_cost_q;
  logic [VALUE_BITS-1:0] res_value_q;
  logic     [KIND_W-1:0] res_kind_q;

  // Row wiring.
  lcrt_ctl_t             ctl;
  lcrt_link_t            link_v [SLOTS+1];
  lcrt_stat_t            stat_v [SLOTS];
  logic      [SLOTS:0]   le_v;
  logic    [SLOTS-1:0]   live_v, rle_v, mlt_v, hit_v;
  logic  [COST_BITS-1:0] cost_v  [SLOTS];
  logic [VALUE_BITS-1:0] value_v [SLOTS];
  logic     [KIND_W-1:0] kind_v  [SLOTS];

  logic             accept, fire;
  logic [CNT_W-1:0] lim, lim_m1, lim_w, cnt1, capped;
  logic             has_m, drop, ins_ok, rd_ok;

  assign accept = in_valid_i && !in_stall_o;
  assign fire   = (state_q == ST_UPDATE) && (!out_valid_q || !out_stall_i);
  assign lim    = clamp_lim(slots_q);
  assign lim_m1 = lim - CNT_W'(1);
  assign lim_w  = clamp_lim(cfg_wdata_i);

  assign link_v[0] = '{after_m: 1'b0, r_le: 1'b1};
  assign le_v[SLOTS] = 1'b0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    localparam int unsigned LI = (i == 0) ? 0 : i - 1;
    localparam int unsigned RI = (i == SLOTS - 1) ? i : i + 1;

    assign live_v[i] = count_q > CNT_W'(i);
    assign rle_v[i]  = link_v[i+1].r_le;
    assign mlt_v[i]  = stat_v[i].match_lt;
    assign hit_v[i]  = stat_v[i].hit;

    lcrt_cell #(
      .COST_BITS  (COST_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .live_i        (live_v[i]),
      .cmp_cost_i    (route_cost_i),
      .cmp_value_i   (route_value_i),
      .cmp_kind_i    (route_kind_i),
      .new_cost_i    (cost_q),
      .new_value_i   (value_q),
      .new_kind_i    (kind_q),
      .left_cost_i   (cost_v[LI]),
      .left_value_i  (value_v[LI]),
      .left_kind_i   (kind_v[LI]),
      .right_cost_i  (cost_v[RI]),
      .right_value_i (value_v[RI]),
      .right_kind_i  (kind_v[RI]),
      .le_right_i    (le_v[i+1]),
      .le_o          (le_v[i]),
      .link_i        (link_v[i]),
      .link_o        (link_v[i+1]),
      .stat_o        (stat_v[i]),
      .cost_o        (cost_v[i]),
      .value_o       (value_v[i]),
      .kind_o        (kind_v[i])
    );
  end

  // Insert decision: drop on zero value or a strictly cheaper duplicate;
  // otherwise the duplicate leaves and the new route goes in if it finds a place below the limit.
  assign has_m  = link_v[SLOTS].after_m;
  assign drop   = (value_q == '0) || (|mlt_v);
  assign ins_ok = !rle_v[lim_m1[IDX_W-1:0]];
  assign cnt1   = count_q - CNT_W'(has_m);
  assign capped = (cnt1 >= lim) ? lim_m1 : cnt1;
  assign rd_ok  = CNT_W'(idx_q) < count_q;

  assign ctl.cmp_en   = accept;
  assign ctl.shift_en = fire && (op_q == OP_INSERT) && !drop;
  assign ctl.ins_ok   = ins_ok;

  always_comb begin
    count_d = count_q;
    case (op_q)
      OP_INSERT: begin
        if (!drop) count_d = ins_ok ? capped + CNT_W'(1) : cnt1;
      end
      OP_CLEAR:  count_d = '0;
      default:   count_d = count_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_UPDATE;
      ST_UPDATE: if (fire) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      slots_q     <= CNT_W'(SLOTS);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        count_q <= count_d;
      end else if (cfg_we_i) begin
        // Lowering the limit drops the costliest routes.
        slots_q <= cfg_wdata_i;
        if (count_q > lim_w) count_q <= lim_w;
      end
      if (fire) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Hold the command for the update cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= opcode_i;
      cost_q  <= route_cost_i;
      value_q <= route_value_i;
      kind_q  <= route_kind_i;
      idx_q   <= slot_index_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_count_q <= count_d;
      res_acc_q   <= (op_q == OP_INSERT) && !drop && ins_ok;
      res_found_q <= (op_q == OP_CONTAINS) && (value_q != '0) && (|hit_v);
      res_valid_q <= (op_q == OP_READ) && rd_ok;
      if ((op_q == OP_READ) && rd_ok) begin
        res_cost_q  <= cost_v[idx_q];
        res_value_q <= value_v[idx_q];
        res_kind_q  <= kind_v[idx_q];
      end else begin
        res_cost_q  <= '0;
        res_value_q <= '0;
        res_kind_q  <= '0;
      end
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign entry_count_o = res_count_q;
  assign accepted_o    = res_acc_q;
  assign value_found_o = res_found_q;
  assign entry_valid_o = res_valid_q;
  assign entry_cost_o  = res_cost_q;
  assign entry_value_o = res_value_q;
  assign entry_kind_o  = res_kind_q;

endmodule

`default_nettype wire

[sim/lcrt_route_checker.sv]
// Route table checker: watches both channels, predicts each result and compares it.
`timescale 1ns / 1ps

module lcrt_route_checker import lcrt_pkg::*; #(
  parameter int unsigned SLOTS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] route_cost_i,
  input  logic [31:0] route_value_i,
  input  logic [7:0]  route_kind_i,
  input  logic [1:0]  slot_index_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  entry_count_i,
  input  logic        accepted_i,
  input  logic        value_found_i,
  input  logic        entry_valid_i,
  input  logic [31:0] entry_cost_i,
  input  logic [31:0] entry_value_i,
  input  logic [7:0]  entry_kind_i,
  output int          mismatch_count_o,
  output int          pending_count_o,
  output int          checked_count_o
);

  typedef struct packed {
    logic [2:0]  count;
    logic        accepted;
    logic        found;
    logic        valid;
    logic [31:0] cost;
    logic [31:0] value;
    logic [7:0]  kind;
  } route_result_t;

  route_result_t pending_route_results[$];

  // Shadow copy of the table and its limit register.
  logic [31:0] tbl_cost  [SLOTS];
  logic [31:0] tbl_value [SLOTS];
  logic [7:0]  tbl_kind  [SLOTS];
  int unsigned tbl_live;
  logic [2:0]  tbl_limit_reg;

  function automatic int unsigned active_limit();
    if (tbl_limit_reg < 3'd1) return 1;
    if (32'(tbl_limit_reg) > SLOTS) return SLOTS;
    return 32'(tbl_limit_reg);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_count_o++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      report_mismatch($sformatf("%s: expected 0x%0h, got 0x%0h", name, want, got));
    end
  endtask

  task automatic insert_route(input logic [31:0] cost, input logic [31:0] value,
                              input logic [7:0] kind, output logic ok);
    int unsigned lim;
    int unsigned pos;
    int unsigned hit;
    int unsigned i;
    ok  = 1'b0;
    lim = active_limit();
    if (value == '0) return;
    hit = tbl_live;
    for (i = 0; i < tbl_live; i++) begin
      if (tbl_value[i] == value && tbl_kind[i] == kind) begin
        hit = i;
        break;
      end
    end
    if (hit < tbl_live) begin
      // Keep the cheaper existing route, else remove it before placing the new one.
      if (tbl_cost[hit] < cost) return;
      for (i = hit; i + 1 < tbl_live; i++) begin
        tbl_cost[i]  = tbl_cost[i+1];
        tbl_value[i] = tbl_value[i+1];
        tbl_kind[i]  = tbl_kind[i+1];
      end
      tbl_live--;
    end
    pos = tbl_live;
    for (i = 0; i < tbl_live; i++) begin
      if (tbl_cost[i] > cost) begin
        pos = i;
        break;
      end
    end
    if (pos >= lim) return;
    if (tbl_live >= lim) tbl_live = lim - 1;
    for (i = tbl_live; i > pos; i--) begin
      tbl_cost[i]  = tbl_cost[i-1];
      tbl_value[i] = tbl_value[i-1];
      tbl_kind[i]  = tbl_kind[i-1];
    end
    tbl_cost[pos]  = cost;
    tbl_value[pos] = value;
    tbl_kind[pos]  = kind;
    tbl_live++;
    ok = 1'b1;
  endtask

  task automatic predict_route_result(output route_result_t res);
    int unsigned i;
    logic ok;
    res = '0;
    case (opcode_i)
      OP_INSERT: begin
        insert_route(route_cost_i, route_value_i, route_kind_i, ok);
        res.accepted = ok;
      end
      OP_CLEAR: begin
        tbl_live = 0;
      end
      OP_READ: begin
        if (32'(slot_index_i) < tbl_live) begin
          res.valid = 1'b1;
          res.cost  = tbl_cost[slot_index_i];
          res.value = tbl_value[slot_index_i];
          res.kind  = tbl_kind[slot_index_i];
        end
      end
      default: begin
        for (i = 0; i < tbl_live; i++) begin
          if (route_value_i != '0 && tbl_value[i] == route_value_i) res.found = 1'b1;
        end
      end
    endcase
    res.count = tbl_live[2:0];
  endtask

  task automatic check_route_result();
    route_result_t want;
    if (pending_route_results.size() == 0) begin
      report_mismatch("result transfer with no command outstanding");
      return;
    end
    want = pending_route_results.pop_front();
    checked_count_o++;
    compare_field("entry_count", 32'(want.count), 32'(entry_count_i));
    compare_field("accepted", 32'(want.accepted), 32'(accepted_i));
    compare_field("value_found", 32'(want.found), 32'(value_found_i));
    compare_field("entry_valid", 32'(want.valid), 32'(entry_valid_i));
    compare_field("entry_cost", want.cost, entry_cost_i);
    compare_field("entry_value", want.value, entry_value_i);
    compare_field("entry_kind", 32'(want.kind), 32'(entry_kind_i));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    route_result_t res;
    if (!rst_ni) begin
      tbl_live      = 0;
      tbl_limit_reg = 3'(SLOTS);
      for (int i = 0; i < SLOTS; i++) begin
        tbl_cost[i]  = '0;
        tbl_value[i] = '0;
        tbl_kind[i]  = '0;
      end
      pending_route_results.delete();
      mismatch_count_o = 0;
      checked_count_o  = 0;
    end else begin
      // Retire a finished result first, then record any new command.
      if (out_valid_i && !out_stall_i) check_route_result();
      if (cfg_we_i) begin
        tbl_limit_reg = cfg_wdata_i;
        if (tbl_live > active_limit()) tbl_live = active_limit();
      end
      if (in_valid_i && !in_stall_i) begin
        predict_route_result(res);
        pending_route_results.push_back(res);
      end
    end
    pending_count_o = pending_route_results.size();
  end

endmodule

[sim/tb_lowest_cost_route_table_core.sv]
// Testbench top for the lowest-cost route table: stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps

module tb_lowest_cost_route_table_core import lcrt_pkg::*;;

  localparam int unsigned SLOTS        = 4;
  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned CHUNK_ITEMS  = 53;

  logic clk = 1'b0;
  logic rst_n;

  logic        cfg_we;
  logic [2:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  opcode;
  logic [31:0] route_cost;
  logic [31:0] route_value;
  logic [7:0]  route_kind;
  logic [1:0]  slot_index;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  entry_count;
  logic        accepted;
  logic        value_found;
  logic        entry_valid;
  logic [31:0] entry_cost;
  logic [31:0] entry_value;
  logic [7:0]  entry_kind;

  int mismatch_count;
  int pending_count;
  int checked_count;

  // Idle rates in percent for the two sides; the stimulus changes them per phase.
  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 63;

  // A long receiver hold-off is requested by bumping hold_requests.
  int unsigned hold_requests = 0;
  int unsigned holds_done    = 0;

  int unsigned cycle_count = 0;
  int unsigned cmds_sent   = 0;
  int unsigned limit_writes = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  lowest_cost_route_table_core #(
    .SLOTS      (SLOTS),
    .COST_BITS  (32),
    .VALUE_BITS (32)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .opcode_i      (opcode),
    .route_cost_i  (route_cost),
    .route_value_i (route_value),
    .route_kind_i  (route_kind),
    .slot_index_i  (slot_index),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .entry_count_o (entry_count),
    .accepted_o    (accepted),
    .value_found_o (value_found),
    .entry_valid_o (entry_valid),
    .entry_cost_o  (entry_cost),
    .entry_value_o (entry_value),
    .entry_kind_o  (entry_kind)
  );

  lcrt_route_checker #(.SLOTS(SLOTS)) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .opcode_i         (opcode),
    .route_cost_i     (route_cost),
    .route_value_i    (route_value),
    .route_kind_i     (route_kind),
    .slot_index_i     (slot_index),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .entry_count_i    (entry_count),
    .accepted_i       (accepted),
    .value_found_i    (value_found),
    .entry_valid_i    (entry_valid),
    .entry_cost_i     (entry_cost),
    .entry_value_i    (entry_value),
    .entry_kind_i     (entry_kind),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .checked_count_o  (checked_count)
  );

  // Watchdog: end the run if the cycle budget runs out.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lowest_cost_route_table_core test failed");
    $finish;
  end

  // Output back-pressure: random stall at the current rate, or a long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_done++;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offer one command, starting at a falling edge. Idle gaps are inserted first;
  // valid is left high on return so a back-to-back command needs no toggle.
  task automatic send_route_cmd(input logic [1:0] op, input logic [31:0] cost,
                                input logic [31:0] value, input logic [7:0] kind,
                                input logic [1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    route_cost  <= cost;
    route_value <= value;
    route_kind  <= kind;
    slot_index  <= idx;
    // Hold the payload until the transfer edge.
    do @(posedge clk); while (in_stall);
    cmds_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait at falling edges until every result has been retired.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Write the table limit only while the block is idle.
  task automatic write_limit(input logic [2:0] limit);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(negedge clk);
    cfg_we    <= 1'b0;
    limit_writes++;
  endtask

  // Random command: small pools for cost, value and kind so that ties, duplicates
  // and hits are common; occasional full-width and extreme values for bit coverage.
  task automatic random_route_cmd();
    int unsigned pick;
    logic [1:0]  op;
    logic [31:0] cost;
    logic [31:0] value;
    logic [7:0]  kind;
    pick = $urandom_range(99);
    if (pick < 52) op = OP_INSERT;
    else if (pick < 74) op = OP_READ;
    else if (pick < 95) op = OP_CONTAINS;
    else op = OP_CLEAR;
    pick = $urandom_range(9);
    if (pick < 6) cost = $urandom_range(0, 7);
    else if (pick < 8) cost = $urandom;
    else if (pick == 8) cost = '0;
    else cost = '1;
    pick = $urandom_range(15);
    if (pick == 0) value = '0;
    else if (pick == 1) value = $urandom;
    else if (pick == 2) value = '1;
    else value = $urandom_range(1, 6);
    kind = ($urandom_range(9) < 8) ? 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 255));
    send_route_cmd(op, cost, value, kind, 2'($urandom_range(0, 3)));
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    opcode      = OP_INSERT;
    route_cost  = '0;
    route_value = '0;
    route_kind  = '0;
    slot_index  = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Empty table: nothing found, nothing to read.
    send_route_cmd(OP_CONTAINS, 32'd0, 32'd0, 8'd0, 2'd0);
    send_route_cmd(OP_READ, 32'd0, 32'd0, 8'd0, 2'd0);
    // A zero value is never stored.
    send_route_cmd(OP_INSERT, 32'd5, 32'd0, 8'd3, 2'd0);
    // Fill the table; the equal-cost route goes after the first one.
    send_route_cmd(OP_INSERT, 32'd100, 32'h11, 8'd1, 2'd0);
    send_route_cmd(OP_INSERT, 32'd100, 32'h22, 8'd2, 2'd0);
    send_route_cmd(OP_INSERT, 32'd0, 32'h33, 8'hFF, 2'd0);
    send_route_cmd(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h80, 2'd0);
    // Full and not cheaper than the costliest: no room.
    send_route_cmd(OP_INSERT, 32'hFFFF_FFFF, 32'h44, 8'd0, 2'd0);
    // Full and cheaper: the costliest route falls off.
    send_route_cmd(OP_INSERT, 32'd50, 32'h55, 8'd7, 2'd0);
    // Existing duplicate is cheaper: drop the insert.
    send_route_cmd(OP_INSERT, 32'd200, 32'h11, 8'd1, 2'd0);
    // Equal cost replaces and moves behind the other equal-cost route; then move it up.
    send_route_cmd(OP_INSERT, 32'd100, 32'h11, 8'd1, 2'd0);
    send_route_cmd(OP_INSERT, 32'd20, 32'h11, 8'd1, 2'd0);
    // Same value, other kind: a separate route.
    send_route_cmd(OP_INSERT, 32'd20, 32'h11, 8'd2, 2'd0);
    send_route_cmd(OP_READ, 32'd0, 32'd0, 8'd0, 2'd0);
    send_route_cmd(OP_READ, 32'd0, 32'd0, 8'd0, 2'd3);
    send_route_cmd(OP_CONTAINS, 32'd0, 32'h11, 8'd0, 2'd0);
    send_route_cmd(OP_CONTAINS, 32'd0, 32'h99, 8'd0, 2'd0);
    send_route_cmd(OP_CONTAINS, 32'd0, 32'd0, 8'd0, 2'd0);
    send_route_cmd(OP_CLEAR, 32'd0, 32'd0, 8'd0, 2'd0);
    send_route_cmd(OP_READ, 32'd0, 32'd0, 8'd0, 2'd3);

    // Limit zero acts as one.
    write_limit(3'd0);
    send_route_cmd(OP_INSERT, 32'd9, 32'h66, 8'd1, 2'd0);
    send_route_cmd(OP_INSERT, 32'd9, 32'h77, 8'd1, 2'd0);
    send_route_cmd(OP_INSERT, 32'd3, 32'h88, 8'd1, 2'd0);
    // Limit above the slot count acts as the slot count; fill, then shrink to two.
    write_limit(3'd7);
    send_route_cmd(OP_INSERT, 32'd4, 32'h99, 8'd1, 2'd0);
    send_route_cmd(OP_INSERT, 32'd8, 32'hAA, 8'd1, 2'd0);
    send_route_cmd(OP_INSERT, 32'd6, 32'hBB, 8'd1, 2'd0);
    write_limit(3'd2);
    send_route_cmd(OP_READ, 32'd0, 32'd0, 8'd0, 2'd1);
    send_route_cmd(OP_READ, 32'd0, 32'd0, 8'd0, 2'd2);
    write_limit(3'd5);

    // Random part in three idling phases, with a new limit every chunk.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int chunk = 0; chunk < 6; chunk++) begin
        write_limit(3'($urandom_range(0, 7)));
        // Hold the output off for a long stretch while commands keep coming.
        if (phase == 2 && chunk == 1) hold_requests++;
        // Pause the sender once mid-chunk until the block has answered everything.
        if (phase == 1 && chunk == 3) begin
          repeat (CHUNK_ITEMS / 2) random_route_cmd();
          drain_results();
          repeat (CHUNK_ITEMS - CHUNK_ITEMS / 2) random_route_cmd();
        end else begin
          repeat (CHUNK_ITEMS) random_route_cmd();
        end
      end
    end

    drain_results();
    repeat (8) @(negedge clk);

    $display("Sent %0d commands over %0d table-limit writes, three idling phases and a long",
             cmds_sent, limit_writes);
    $display("output hold-off; %0d results compared, %0d mismatches.",
             checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("lowest_cost_route_table_core test passed");
    end else begin
      $display("lowest_cost_route_table_core test failed");
    end
    $finish;
  end

endmodule
